// ===== hw/rtl/rtbr_pkg.sv =====
// shared types, nibble codes and helpers for the register-to-barcode-row block
package rtbr_pkg;

  localparam int ROW_BYTES = 9;
  localparam int NIB_SLOTS = 18;

  localparam logic [3:0] NIB_NUM_TYPE = 4'd6;
  localparam logic [3:0] NIB_MINUS    = 4'd13;
  localparam logic [3:0] NIB_POINT    = 4'd11;
  localparam logic [3:0] NIB_EEX      = 4'd14;
  localparam logic [3:0] NIB_PAD      = 4'd10;

  localparam logic [3:0] TYPE_POS   = 4'h0;
  localparam logic [3:0] TYPE_NEG   = 4'h9;
  localparam logic [3:0] TYPE_ALPHA = 4'h1;

  localparam logic [7:0] ALPHA_HDR = 8'h70;

  localparam int WARN_DIG   = 0;
  localparam int WARN_CLAMP = 1;
  localparam int WARN_DROP  = 2;
  localparam int WARN_ALPHA = 3;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_NUM,
    KIND_ALPHA
  } kind_t;

  typedef logic [ROW_BYTES-1:0][7:0] row_data_t;

  typedef struct packed {
    row_data_t  data;
    logic [3:0] len;
    logic [7:0] csum;
    logic [3:0] warn;
  } row_t;

  // end-around-carry fold of a plain byte sum
  function automatic logic [7:0] fold_csum(input logic [11:0] s);
    logic [8:0] t;
    t = {1'b0, s[7:0]} + {5'b0, s[11:8]};
    return t[7:0] + {7'b0, t[8]};
  endfunction

  function automatic logic [3:0] clamp_dig(input logic [3:0] d);
    return (d > 4'd9) ? 4'd9 : d;
  endfunction

endpackage

// ===== hw/rtl/rtbr_front.sv =====
// front pipeline: accepts registers, decodes the exponent, builds row bytes and their sum
module rtbr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [55:0]          in_register_word,
  input  logic                 cfg_wr,
  input  logic                 cfg_short_form_mode,
  output logic                 q_push,
  output rtbr_pkg::row_t       q_row,
  input  logic                 q_full
);
  import rtbr_pkg::*;

  logic adv;
  logic mode_r;

  // stage 1: classify and decode exponent
  logic               s1_valid_r;
  kind_t              s1_kind_r;
  logic [55:0]        s1_word_r;
  logic               s1_mode_r;
  logic signed [11:0] s1_exp_r;
  kind_t              in_kind;
  logic [10:0]        e_raw;
  logic signed [11:0] s1_exp_nxt;

  // stage 2: short form, tenth digit, exponent clamp
  logic               s2_valid_r;
  kind_t              s2_kind_r;
  logic [55:0]        s2_word_r;
  logic               s2_neg_r, s2_sf_r, s2_tenth_r, s2_drop_r;
  logic               s2_eex_r, s2_eneg_r, s2_clamp_r;
  logic [6:0]         s2_mag_r;
  logic               neg, ez, sf, d9nz, drop, tenth, clampw;
  logic signed [11:0] e2, eabs;

  // stage 3: row bytes
  logic               s3_valid_r;
  row_data_t          s3_data_r;
  logic [3:0]         s3_len_r;
  logic [3:0]         s3_warn_r;
  row_data_t          s3_data_nxt;
  logic [3:0]         s3_len_nxt;
  logic [3:0]         s3_warn_nxt;

  // stage 4: byte sum
  logic               s4_valid_r;
  row_data_t          s4_data_r;
  logic [3:0]         s4_len_r;
  logic [3:0]         s4_warn_r;
  logic [11:0]        s4_sum_r;
  logic [11:0]        sum_nxt;

  // numeric build signals
  logic [3:0]  dg [10];
  logic [3:0]  nib [NIB_SLOTS];
  logic [14:0] prod;
  logic [3:0]  tens, units;
  logic        tens_nz, dig_over;
  logic [4:0]  p_d0, p_m, p_t, p_x, p_ng, p_tn, p_un, cnt, cnt_up;
  row_data_t   num_data;
  logic [3:0]  num_len, num_warn;

  // alpha build signals
  logic [2:0]  first;
  logic [47:0] alpha_body;
  row_data_t   alpha_data;
  logic [3:0]  alpha_len, alpha_warn;

  assign adv  = !(s4_valid_r && q_full);
  assign busy = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr) begin
      mode_r <= cfg_short_form_mode;
    end
  end

  // ---------------- stage 1 ----------------
  always_comb begin
    case (in_register_word[55:52])
      TYPE_POS, TYPE_NEG: in_kind = KIND_NUM;
      TYPE_ALPHA:         in_kind = KIND_ALPHA;
      default:            in_kind = KIND_NONE;
    endcase
    e_raw = {7'b0, in_register_word[11:8]} * 11'd100
          + {7'b0, in_register_word[7:4]} * 11'd10
          + {7'b0, in_register_word[3:0]};
    s1_exp_nxt = (e_raw >= 11'd500) ? $signed({1'b0, e_raw}) - 12'sd1000
                                    : $signed({1'b0, e_raw});
  end

  // ---------------- stage 2 ----------------
  always_comb begin
    neg    = (s1_word_r[55:52] == TYPE_NEG);
    ez     = (s1_exp_r == 12'sd0);
    sf     = s1_mode_r && !ez && (s1_exp_r >= -12'sd90);
    e2     = sf ? s1_exp_r - 12'sd9 : s1_exp_r;
    d9nz   = (s1_word_r[15:12] != 4'd0);
    drop   = !sf && d9nz && s1_mode_r && !ez && (s1_exp_r < -12'sd9) && neg;
    tenth  = sf || (d9nz && !drop);
    clampw = (e2 > 12'sd99) || (e2 < -12'sd99);
    eabs   = e2[11] ? -e2 : e2;
  end

  // ---------------- stage 3: numeric ----------------
  always_comb begin
    // mantissa digits start below the type nibble
    for (int i = 0; i < 10; i++) begin
      dg[i] = s2_word_r[51-4*i -: 4];
    end
    // divide by ten through a reciprocal, exact for values up to 99
    prod    = {8'b0, s2_mag_r} * 15'd205;
    tens    = prod[14:11];
    units   = 4'(s2_mag_r - {3'b0, tens} * 7'd10);
    tens_nz = (s2_mag_r >= 7'd10);

    dig_over = s2_tenth_r && (dg[9] > 4'd9);
    for (int i = 0; i < 9; i++) begin
      if (dg[i] > 4'd9) dig_over = 1'b1;
    end

    p_d0   = 5'd1 + {4'b0, s2_neg_r};
    p_m    = p_d0 + 5'd1 + {4'b0, !s2_sf_r};
    p_t    = p_m + 5'd8;
    p_x    = p_t + {4'b0, s2_tenth_r};
    p_ng   = p_x + 5'd1;
    p_tn   = p_ng + {4'b0, s2_eneg_r};
    p_un   = p_tn + {4'b0, tens_nz};
    cnt    = s2_eex_r ? p_un + 5'd1 : p_x;
    cnt_up = cnt + 5'd1;

    for (int j = 0; j < NIB_SLOTS; j++) begin
      nib[j] = NIB_PAD;
      if (j == 0) begin
        nib[j] = NIB_NUM_TYPE;
      end else if (s2_neg_r && j == 1) begin
        nib[j] = NIB_MINUS;
      end else if (5'(j) == p_d0) begin
        nib[j] = clamp_dig(dg[0]);
      end else if (!s2_sf_r && 5'(j) == p_d0 + 5'd1) begin
        nib[j] = NIB_POINT;
      end else if (5'(j) >= p_m && 5'(j) < p_t) begin
        nib[j] = clamp_dig(dg[4'd1 + {1'b0, 3'(5'(j) - p_m)}]);
      end else if (s2_tenth_r && 5'(j) == p_t) begin
        nib[j] = clamp_dig(dg[9]);
      end else if (s2_eex_r && 5'(j) == p_x) begin
        nib[j] = NIB_EEX;
      end else if (s2_eex_r && s2_eneg_r && 5'(j) == p_ng) begin
        nib[j] = NIB_MINUS;
      end else if (s2_eex_r && tens_nz && 5'(j) == p_tn) begin
        nib[j] = tens;
      end else if (s2_eex_r && 5'(j) == p_un) begin
        nib[j] = units;
      end
    end

    for (int k = 0; k < ROW_BYTES; k++) begin
      num_data[k] = {nib[2*k], nib[2*k+1]};
    end
    num_len              = cnt_up[4:1];
    num_warn             = '0;
    num_warn[WARN_DIG]   = dig_over;
    num_warn[WARN_CLAMP] = s2_clamp_r;
    num_warn[WARN_DROP]  = s2_drop_r;
  end

  // ---------------- stage 3: alpha ----------------
  always_comb begin
    // leading null characters are skipped, the last byte always stays
    if (s2_word_r[47:40] != 8'd0)      first = 3'd1;
    else if (s2_word_r[39:32] != 8'd0) first = 3'd2;
    else if (s2_word_r[31:24] != 8'd0) first = 3'd3;
    else if (s2_word_r[23:16] != 8'd0) first = 3'd4;
    else if (s2_word_r[15:8] != 8'd0)  first = 3'd5;
    else                               first = 3'd6;
    alpha_body    = s2_word_r[47:0] << {first - 3'd1, 3'b000};
    alpha_data    = '0;
    alpha_data[0] = ALPHA_HDR + {5'b0, 3'd7 - first};
    for (int k = 1; k < 7; k++) begin
      alpha_data[k] = alpha_body[47-8*(k-1) -: 8];
    end
    alpha_len              = 4'd8 - {1'b0, first};
    alpha_warn             = '0;
    alpha_warn[WARN_ALPHA] = (s2_word_r[51:48] != 4'd0);
  end

  always_comb begin
    if (s2_kind_r == KIND_ALPHA) begin
      s3_data_nxt = alpha_data;
      s3_len_nxt  = alpha_len;
      s3_warn_nxt = alpha_warn;
    end else begin
      s3_data_nxt = num_data;
      s3_len_nxt  = num_len;
      s3_warn_nxt = num_warn;
    end
  end

  // ---------------- stage 4 ----------------
  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < ROW_BYTES; k++) begin
      if (4'(k) < s3_len_r) sum_nxt = sum_nxt + {4'b0, s3_data_r[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= start && (in_kind != KIND_NONE);
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r  <= in_kind;
      s1_word_r  <= in_register_word;
      s1_mode_r  <= mode_r;
      s1_exp_r   <= s1_exp_nxt;

      s2_kind_r  <= s1_kind_r;
      s2_word_r  <= s1_word_r;
      s2_neg_r   <= neg;
      s2_sf_r    <= sf;
      s2_tenth_r <= tenth;
      s2_drop_r  <= drop;
      s2_eex_r   <= (e2 != 12'sd0);
      s2_eneg_r  <= e2[11];
      s2_clamp_r <= clampw;
      s2_mag_r   <= clampw ? 7'd99 : eabs[6:0];

      s3_data_r  <= s3_data_nxt;
      s3_len_r   <= s3_len_nxt;
      s3_warn_r  <= s3_warn_nxt;

      s4_data_r  <= s3_data_r;
      s4_len_r   <= s3_len_r;
      s4_warn_r  <= s3_warn_r;
      s4_sum_r   <= sum_nxt;
    end
  end

  assign q_push     = s4_valid_r && !q_full;
  assign q_row.data = s4_data_r;
  assign q_row.len  = s4_len_r;
  assign q_row.csum = fold_csum(s4_sum_r);
  assign q_row.warn = s4_warn_r;

endmodule

// ===== hw/rtl/rtbr_queue.sv =====
// short row queue between the front pipeline and the byte serializer
module rtbr_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rtbr_pkg::row_t push_row,
  output logic           full,
  input  logic           pop,
  output rtbr_pkg::row_t head,
  output logic           empty
);
  import rtbr_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  row_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_row;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("row pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("row popped from empty queue");

endmodule

// ===== hw/rtl/rtbr_back.sv =====
// byte serializer: sends length, checksum and data of each queued row
module rtbr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  rtbr_pkg::row_t head,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  output logic [7:0]     out_row_byte,
  output logic           out_last_byte,
  output logic [3:0]     out_warn_flags
);
  import rtbr_pkg::*;

  logic [3:0] idx_r, idx_nxt;
  logic [3:0] dsel;
  logic       is_last;
  logic [7:0] byte_sel;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [3:0] out_warn_r;

  always_comb begin
    dsel    = idx_r - 4'd2;
    is_last = (idx_r == head.len + 4'd1);
    case (idx_r)
      4'd0:    byte_sel = {4'b0, head.len};
      4'd1:    byte_sel = head.csum;
      default: byte_sel = head.data[dsel];
    endcase
    pop = !empty && is_last;
    if (empty)        idx_nxt = idx_r;
    else if (is_last) idx_nxt = '0;
    else              idx_nxt = idx_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= byte_sel;
    out_last_r <= is_last;
    out_warn_r <= is_last ? head.warn : 4'd0;
  end

  assign out_valid      = out_valid_r;
  assign out_row_byte   = out_byte_r;
  assign out_last_byte  = out_last_r;
  assign out_warn_flags = out_warn_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> idx_r <= head.len + 4'd1) else $error("byte index past row end");

  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> idx_r == 4'd0) else $error("serializer idle in mid row");

  a_row_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |=> out_valid_r) else $error("gap inside a row");

endmodule

// ===== hw/rtl/register_to_barcode_row.sv =====
// top level: register in, barcode row bytes out, one config bit for short form
// the first byte of a row passes the front stages, the row queue and the serializer output register
// a row of n data bytes leaves as n+2 bytes (4 to 11), one byte per cycle
// the byte serializer sets the sustained rate; start is taken every cycle while busy is low
// registers of unknown type are dropped on entry to the front and give no bytes
// reset: synchronous, active low; clears pipeline, queue and short form mode, no sweep
module register_to_barcode_row #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [55:0] in_register_word,
  output logic        out_valid,
  output logic [7:0]  out_row_byte,
  output logic        out_last_byte,
  output logic [3:0]  out_warn_flags,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_short_form_mode
);
  import rtbr_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  row_t q_in, q_head;

  assign cfg_ready = 1'b1;

  rtbr_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_register_word    (in_register_word),
    .cfg_wr              (cfg_valid && cfg_ready),
    .cfg_short_form_mode (cfg_short_form_mode),
    .q_push              (q_push),
    .q_row               (q_in),
    .q_full              (q_full)
  );

  rtbr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_row (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  rtbr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .empty          (q_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_row_byte   (out_row_byte),
    .out_last_byte  (out_last_byte),
    .out_warn_flags (out_warn_flags)
  );

endmodule
